// ----- design/poa_pkg.sv -----
// ----------------------------------------------------------------------------
// Position odometer package
// Shared operation codes, constants and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package poa_pkg;

  // Width of the stale limit register.
  localparam int unsigned LIMIT_BITS = 32;

  // Bits of the multiplier operand consumed per multiply step.
  localparam int unsigned MUL_DIGIT = 4;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_X     = 2'd0;
  localparam logic [1:0] OP_Y     = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_x;
    logic take_y;
    logic take_clear;
    logic take_tick;
    logic mul_load;
    logic mul_step;
    logic root_load;
    logic root_step;
    logic finish;
  } poa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_pending;
    logic pair_fresh;
    logic out_free;
  } poa_status_t;

endpackage

// ----- design/poa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Position odometer controller
// Sequences item intake, the squaring steps, the square-root steps and the
// final commit of each update tick.
// ----------------------------------------------------------------------------
module poa_ctrl #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_op_i,
  output logic                 in_ready_o,
  input  poa_pkg::poa_status_t status_i,
  output poa_pkg::poa_cmd_t    cmd_o
);

  localparam int unsigned MUL_STEPS  =
    (POS_BITS + poa_pkg::MUL_DIGIT - 1) / poa_pkg::MUL_DIGIT;
  localparam int unsigned ROOT_STEPS = POS_BITS + 1;
  localparam int unsigned CW         = $clog2(ROOT_STEPS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i & in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (in_op_i)
            poa_pkg::OP_X:     cmd_o.take_x = 1'b1;
            poa_pkg::OP_Y:     cmd_o.take_y = 1'b1;
            poa_pkg::OP_CLEAR: cmd_o.take_clear = 1'b1;
            poa_pkg::OP_TICK: begin
              cmd_o.take_tick = 1'b1;
              if (!status_i.clear_pending && status_i.pair_fresh) begin
                cmd_o.mul_load = 1'b1;
                cnt_d          = '0;
                state_d        = ST_MUL;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == CW'(MUL_STEPS - 1)) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SUM: begin
        cmd_o.root_load = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CW'(ROOT_STEPS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- design/poa_datapath.sv -----
// ----------------------------------------------------------------------------
// Position odometer datapath
// Holds positions, flags, the total and the stale limit, squares the axis
// steps four bits at a time, takes the square root one bit per cycle and
// drives the output register.
// ----------------------------------------------------------------------------
module poa_datapath #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned DIST_BITS = 48,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  poa_pkg::poa_cmd_t                cmd_i,
  output poa_pkg::poa_status_t             status_o,
  input  logic [POS_BITS-1:0]              position_mm_i,
  input  logic [TIME_BITS-1:0]             now_ms_i,
  input  logic                             stale_limit_we_i,
  input  logic [poa_pkg::LIMIT_BITS-1:0]   stale_limit_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [DIST_BITS-1:0]             total_distance_mm_o,
  output logic                             stale_warning_o
);

  localparam int unsigned DG        = poa_pkg::MUL_DIGIT;
  localparam int unsigned MUL_STEPS = (POS_BITS + DG - 1) / DG;
  localparam int unsigned LW        = MUL_STEPS * DG;
  localparam int unsigned PW        = POS_BITS + DG;
  localparam int unsigned NW        = 2 * POS_BITS + 2;
  localparam int unsigned RW        = POS_BITS + 4;
  localparam int unsigned SW        =
    ((DIST_BITS > POS_BITS + 1) ? DIST_BITS : POS_BITS + 1) + 1;
  localparam int unsigned EW        =
    (TIME_BITS > poa_pkg::LIMIT_BITS) ? TIME_BITS : poa_pkg::LIMIT_BITS;

  // Odometer state.
  logic [POS_BITS-1:0]            cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic [POS_BITS-1:0]            cur_x_d, cur_y_d, prev_x_d, prev_y_d;
  logic [DIST_BITS-1:0]           total_q, total_d;
  logic                           fresh_x_q, fresh_y_q, fresh_x_d, fresh_y_d;
  logic                           awaiting_q, awaiting_d;
  logic                           clear_q, clear_d;
  logic [TIME_BITS-1:0]           last_time_q, last_time_d;
  logic                           seen_q, seen_d;
  logic                           warn_q, warn_d;
  logic [poa_pkg::LIMIT_BITS-1:0] limit_q;
  logic [TIME_BITS-1:0]           tick_time_q;

  // Arithmetic state.
  logic [POS_BITS-1:0]            mul_a_q  [2];
  logic [POS_BITS-1:0]            mul_hi_q [2];
  logic [LW-1:0]                  mul_lo_q [2];
  logic [POS_BITS-1:0]            mag      [2];
  logic [POS_BITS:0]              diff     [2];
  logic [PW-1:0]                  mul_sum  [2];
  logic [POS_BITS+LW-1:0]         prod     [2];
  logic [NW-1:0]                  rad_q;
  logic [RW-1:0]                  rem_q, rem_t, trial;
  logic [POS_BITS:0]              root_q;
  logic [SW-1:0]                  sat_sum;
  logic [TIME_BITS-1:0]           elapsed;

  // Output register.
  logic                           out_valid_q, out_valid_d;
  logic [DIST_BITS-1:0]           out_total_q;
  logic                           out_warn_q;

  // Axis step magnitudes and one multiply digit per lane.
  always_comb begin
    diff[0] = {cur_x_q[POS_BITS-1], cur_x_q} - {prev_x_q[POS_BITS-1], prev_x_q};
    diff[1] = {cur_y_q[POS_BITS-1], cur_y_q} - {prev_y_q[POS_BITS-1], prev_y_q};
    for (int i = 0; i < 2; i++) begin
      mag[i]     = diff[i][POS_BITS] ? POS_BITS'(-diff[i]) : diff[i][POS_BITS-1:0];
      mul_sum[i] = PW'(mul_hi_q[i]) + PW'(mul_a_q[i]) * PW'(mul_lo_q[i][DG-1:0]);
      prod[i]    = {mul_hi_q[i], mul_lo_q[i]};
    end
  end

  // One restoring square-root step.
  always_comb begin
    rem_t = {rem_q[RW-3:0], rad_q[NW-1 -: 2]};
    trial = RW'({root_q, 2'b01});
  end

  // Saturating add and elapsed time.
  assign sat_sum = SW'(total_q) + SW'(root_q);
  assign elapsed = tick_time_q - last_time_q;

  // Odometer state update on intake and on commit of a tick.
  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    total_d     = total_q;
    fresh_x_d   = fresh_x_q;
    fresh_y_d   = fresh_y_q;
    awaiting_d  = awaiting_q;
    clear_d     = clear_q;
    last_time_d = last_time_q;
    seen_d      = seen_q;
    warn_d      = warn_q;

    if (cmd_i.take_x) begin
      cur_x_d   = position_mm_i;
      fresh_x_d = 1'b1;
      if (awaiting_q) begin
        prev_x_d = position_mm_i;
      end
    end
    if (cmd_i.take_y) begin
      cur_y_d   = position_mm_i;
      fresh_y_d = 1'b1;
      if (awaiting_q) begin
        prev_y_d = position_mm_i;
      end
    end
    if (cmd_i.take_x || cmd_i.take_y) begin
      last_time_d = now_ms_i;
      seen_d      = 1'b1;
    end
    if (cmd_i.take_clear) begin
      clear_d = 1'b1;
    end
    if ((cmd_i.take_x || cmd_i.take_y || cmd_i.take_clear || cmd_i.take_tick)
        && fresh_x_d && fresh_y_d) begin
      awaiting_d = 1'b0;
    end

    if (cmd_i.finish) begin
      if (clear_q) begin
        // A pending reset zeroes the total and leaves the warning alone.
        total_d   = '0;
        prev_x_d  = cur_x_q;
        prev_y_d  = cur_y_q;
        fresh_x_d = 1'b0;
        fresh_y_d = 1'b0;
        clear_d   = 1'b0;
      end else begin
        if (fresh_x_q && fresh_y_q) begin
          total_d   = (sat_sum > SW'({DIST_BITS{1'b1}})) ? '1
                                                          : sat_sum[DIST_BITS-1:0];
          prev_x_d  = cur_x_q;
          prev_y_d  = cur_y_q;
          fresh_x_d = 1'b0;
          fresh_y_d = 1'b0;
        end
        if (limit_q != '0) begin
          warn_d = seen_q && (EW'(elapsed) > EW'(limit_q));
        end
      end
    end
  end

  // Output handshake.
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  assign status_o.clear_pending = clear_q;
  assign status_o.pair_fresh    = fresh_x_q & fresh_y_q;
  assign status_o.out_free      = ~out_valid_q | out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign total_distance_mm_o = out_total_q;
  assign stale_warning_o     = out_warn_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      total_q     <= '0;
      fresh_x_q   <= 1'b0;
      fresh_y_q   <= 1'b0;
      awaiting_q  <= 1'b1;
      clear_q     <= 1'b0;
      last_time_q <= '0;
      seen_q      <= 1'b0;
      warn_q      <= 1'b0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      total_q     <= total_d;
      fresh_x_q   <= fresh_x_d;
      fresh_y_q   <= fresh_y_d;
      awaiting_q  <= awaiting_d;
      clear_q     <= clear_d;
      last_time_q <= last_time_d;
      seen_q      <= seen_d;
      warn_q      <= warn_d;
      out_valid_q <= out_valid_d;
      if (stale_limit_we_i) begin
        limit_q <= stale_limit_i;
      end
    end
  end

  // Arithmetic and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_tick) begin
      tick_time_q <= now_ms_i;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.mul_load) begin
        mul_a_q[i]  <= mag[i];
        mul_hi_q[i] <= '0;
        mul_lo_q[i] <= LW'(mag[i]);
      end else if (cmd_i.mul_step) begin
        mul_hi_q[i] <= mul_sum[i][PW-1:DG];
        mul_lo_q[i] <= {mul_sum[i][DG-1:0], mul_lo_q[i][LW-1:DG]};
      end
    end
    if (cmd_i.root_load) begin
      rad_q  <= NW'(prod[0][2*POS_BITS-1:0]) + NW'(prod[1][2*POS_BITS-1:0]);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[NW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[POS_BITS-1:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[POS_BITS-1:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      out_total_q <= total_d;
      out_warn_q  <= warn_d;
    end
  end

endmodule

// ----- design/position_odometer_accumulator.sv -----
// ----------------------------------------------------------------------------
// Position odometer accumulator
// Accumulates the planar path length of an x/y position stream and raises
// a warning when position samples stop arriving.
// ----------------------------------------------------------------------------
// Flow: x, y and reset-request items are taken while idle and give no
// result. A tick that applies a pending reset or has no fresh pair goes to
// the finish state; one with a fresh pair first squares the steps four bits
// at a time, sums them and takes the root one bit per step. Finish commits the
// result once the output is free; no new item is taken until then. Reset
// clears the state, stale limit and output valid, not arithmetic or payload.
module position_odometer_accumulator #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned DIST_BITS = 48,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: position_mm [POS_BITS-1:0], now_ms [next TIME_BITS bits], zero pad
  input  logic [((POS_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: operation [1:0]
  input  logic [1:0]                     s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: total_distance_mm [DIST_BITS-1:0], zero pad
  output logic [((DIST_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: stale_warning [0]
  output logic [0:0]                     m_axis_tuser,
  // Stale limit register.
  input  logic                           stale_limit_we_i,
  input  logic [poa_pkg::LIMIT_BITS-1:0] stale_limit_i
);

  localparam int unsigned OUT_W = ((DIST_BITS + 7) / 8) * 8;

  poa_pkg::poa_cmd_t    cmd;
  poa_pkg::poa_status_t status;
  logic [DIST_BITS-1:0] total;
  logic                 warn;

  // Sequencing.
  poa_ctrl #(
    .POS_BITS (POS_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // State and arithmetic.
  poa_datapath #(
    .POS_BITS  (POS_BITS),
    .DIST_BITS (DIST_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .position_mm_i       (s_axis_tdata[POS_BITS-1:0]),
    .now_ms_i            (s_axis_tdata[POS_BITS +: TIME_BITS]),
    .stale_limit_we_i    (stale_limit_we_i),
    .stale_limit_i       (stale_limit_i),
    .out_ready_i         (m_axis_tready),
    .out_valid_o         (m_axis_tvalid),
    .total_distance_mm_o (total),
    .stale_warning_o     (warn)
  );

  assign m_axis_tdata = OUT_W'(total);
  assign m_axis_tuser = warn;

endmodule

// ----- design/poa_checker.sv -----
// ----------------------------------------------------------------------------
// Position odometer checker
// Port-level checks on the result stream and on how ticks occupy the block.
// ----------------------------------------------------------------------------
module poa_checker #(
  parameter int unsigned DIST_BITS = 48
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [((DIST_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  // No result is offered while reset is held.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An accepted tick keeps the block busy in the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == poa_pkg::OP_TICK) |=>
      !s_axis_tready)
    else $error("input ready right after a tick");

  // A new result only appears while intake is closed.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result rose while block was idle");

  // Samples and reset requests never produce a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != poa_pkg::OP_TICK) &&
      !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result from a non-tick item");

endmodule

bind position_odometer_accumulator poa_checker #(
  .DIST_BITS (DIST_BITS)
) u_poa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
